@@ sv/afk_pkg.sv @@
`timescale 1ns / 1ps
package afk_pkg;

  localparam int NJ      = 7;
  localparam int NREG    = 7;
  localparam int NLINK   = 8;
  localparam int FRAC    = 28;
  localparam int TRIG_ST = 18;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [17:0] reg_t;
  typedef logic signed [29:0] trig_t;
  typedef logic        [28:0] ufr_t;
  typedef logic signed [31:0] rot_t;
  typedef logic signed [39:0] pos_t;
  typedef logic signed [33:0] prd_t;
  typedef logic signed [30:0] ofs_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } cs_t;

  typedef struct packed {
    rot_t [2:0][2:0] rot;
    pos_t [2:0]      pos;
    cs_t  [NJ-1:0]   cs;
  } chain_t;

  localparam ufr_t ONE_Q = ufr_t'(1) << FRAC;
  localparam logic signed [35:0] HALF_PI_Q    = 36'sd421657428;
  localparam logic signed [35:0] QUARTER_PI_Q = 36'sd210828714;

  localparam logic [2:0] REG_BASE_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_SHOULDER     = 3'd1;
  localparam logic [2:0] REG_ELBOW_OUT    = 3'd2;
  localparam logic [2:0] REG_ELBOW_BACK   = 3'd3;
  localparam logic [2:0] REG_FOREARM      = 3'd4;
  localparam logic [2:0] REG_WRIST        = 3'd5;
  localparam logic [2:0] REG_FLANGE       = 3'd6;

  localparam reg_t REG_RESET [NREG] = '{
    18'sd21824, 18'sd20709, 18'sd5407, 18'sd5407, 18'sd25166, 18'sd5767, 18'sd7012
  };

  // Twist pattern per link; the last entry is the flange, an identity rotation.
  localparam int LINK_SA [NLINK] = '{0, -1, 1, 1, -1, 1, 1, 0};
  localparam int LINK_CA [NLINK] = '{1, 0, 0, 0, 0, 0, 0, 1};

  localparam int SIN_DIV [4] = '{72, 42, 20, 6};
  localparam int COS_DIV [5] = '{90, 56, 30, 12, 2};

  localparam cs_t CS_ID = '{c: trig_t'(ONE_Q), s: trig_t'(0)};

  function automatic logic signed [63:0] rnd_q28(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] q;
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
    return p[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic prd_t mulq(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return prd_t'(rnd_q28(p));
  endfunction

endpackage

@@ sv/afk_if.sv @@
`timescale 1ns / 1ps
interface afk_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] joint_angle_0;
  logic signed [15:0] joint_angle_1;
  logic signed [15:0] joint_angle_2;
  logic signed [15:0] joint_angle_3;
  logic signed [15:0] joint_angle_4;
  logic signed [15:0] joint_angle_5;
  logic signed [15:0] joint_angle_6;

  modport source (output valid, output joint_angle_0, output joint_angle_1,
                  output joint_angle_2, output joint_angle_3, output joint_angle_4,
                  output joint_angle_5, output joint_angle_6, input ready);
  modport sink (input valid, input joint_angle_0, input joint_angle_1,
                input joint_angle_2, input joint_angle_3, input joint_angle_4,
                input joint_angle_5, input joint_angle_6, output ready);
endinterface

interface afk_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rot_r0_c0;
  logic signed [17:0] rot_r0_c1;
  logic signed [17:0] rot_r0_c2;
  logic signed [17:0] rot_r1_c0;
  logic signed [17:0] rot_r1_c1;
  logic signed [17:0] rot_r1_c2;
  logic signed [17:0] rot_r2_c0;
  logic signed [17:0] rot_r2_c1;
  logic signed [17:0] rot_r2_c2;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;

  modport source (output valid, output rot_r0_c0, output rot_r0_c1, output rot_r0_c2,
                  output rot_r1_c0, output rot_r1_c1, output rot_r1_c2,
                  output rot_r2_c0, output rot_r2_c1, output rot_r2_c2,
                  output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input rot_r0_c0, input rot_r0_c1, input rot_r0_c2,
                input rot_r1_c0, input rot_r1_c1, input rot_r1_c2,
                input rot_r2_c0, input rot_r2_c1, input rot_r2_c2,
                input pos_x, input pos_y, input pos_z, output ready);
endinterface

@@ sv/arm_forward_kinematics_dh_top.sv @@
// Seven-joint arm forward kinematics, one pose per beat.
// The input channel in_ch carries one beat of seven joint angles (signed Q3.12 radians).
// The output channel out_ch returns one beat per input beat, in order: the nine rotation
// entries (signed Q1.16) and the x, y, z position (signed Q3.16 metres), all saturated.
// The user writes the link offsets over cfg_we, cfg_index and cfg_wdata only while idle
// (the block does not enforce this); an index beyond the seven registers is ignored.
// The datapath is a 35-stage pipeline: 18 stages of sine and cosine per joint, two
// stages per link for the seven links and the flange, and one rounding stage that
// drives the output register. While out_ch.ready stays high, a new beat is accepted
// every cycle.
// Each stage has its own valid bit; a stage takes new data when it is empty or when the
// stage after it moves, so empty stages close up while out_ch is stalled and in_ch.ready
// drops only when every stage holds a beat.
// Reset clears all valid bits and loads the offset registers with their default values.
`timescale 1ns / 1ps
module arm_forward_kinematics_dh_top import afk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  afk_in_if.sink      in_ch,
  afk_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  localparam int NST   = TRIG_ST + 2 * NLINK + 1;
  localparam int OUT_S = NST - 1;

  logic [NST-1:0] v_r, v_nxt, ld;
  reg_t           cfg_r [NREG];
  ofs_t           ofs [NREG];
  ofs_t [2:0]     lp [NLINK];
  ang_t           ang [NJ];
  cs_t            cs [NJ];
  chain_t         ch [NLINK+1];

  logic signed [17:0] rot_o_r [3][3];
  logic signed [19:0] pos_o_r [3];

  function automatic logic signed [39:0] rnd12(input logic signed [39:0] v);
    logic [39:0] mag;
    logic [39:0] q;
    mag = v[39] ? 40'(-v) : 40'(v);
    q   = (mag + 40'd2048) >> 12;
    return v[39] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [17:0] sat_rot(input rot_t v);
    logic signed [39:0] q;
    logic signed [17:0] res;
    q = rnd12(40'(v));
    if (q > 40'sd131071) res = 18'h1FFFF;
    else if (q < -40'sd131072) res = 18'h20000;
    else res = q[17:0];
    return res;
  endfunction

  function automatic logic signed [19:0] sat_pos(input pos_t v);
    logic signed [39:0] q;
    logic signed [19:0] res;
    q = rnd12(v);
    if (q > 40'sd524287) res = 20'h7FFFF;
    else if (q < -40'sd524288) res = 20'h80000;
    else res = q[19:0];
    return res;
  endfunction

  always_comb begin
    ld[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_nxt = {v_r[NST-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (ld[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= REG_RESET;
    end else if (cfg_we && (cfg_index < 3'(NREG))) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < NREG; i++) begin
      ofs[i] = ofs_t'($signed({cfg_r[i], 12'b0}));
    end
    for (int j = 0; j < NLINK; j++) begin
      lp[j] = '0;
    end
    lp[0][2] = ofs[REG_BASE_HEIGHT];
    lp[2][1] = ofs[REG_SHOULDER];
    lp[3][0] = ofs[REG_ELBOW_OUT];
    lp[4][0] = ofs[REG_ELBOW_BACK];
    lp[4][1] = -ofs[REG_FOREARM];
    lp[6][0] = ofs[REG_WRIST];
    lp[7][2] = ofs[REG_FLANGE];
  end

  assign ang[0] = in_ch.joint_angle_0;
  assign ang[1] = in_ch.joint_angle_1;
  assign ang[2] = in_ch.joint_angle_2;
  assign ang[3] = in_ch.joint_angle_3;
  assign ang[4] = in_ch.joint_angle_4;
  assign ang[5] = in_ch.joint_angle_5;
  assign ang[6] = in_ch.joint_angle_6;

  for (genvar j = 0; j < NJ; j++) begin : g_trig
    afk_trig u_trig (
      .clk  (clk),
      .en   (ld[TRIG_ST-1:0]),
      .ang  (ang[j]),
      .cs_o (cs[j])
    );
  end

  always_comb begin
    ch[0].rot = '0;
    ch[0].pos = '0;
    for (int i = 0; i < 3; i++) begin
      ch[0].rot[i][i] = rot_t'(ONE_Q);
    end
    for (int j = 0; j < NJ; j++) begin
      ch[0].cs[j] = cs[j];
    end
  end

  for (genvar j = 0; j < NLINK; j++) begin : g_link
    afk_link #(.J(j)) u_link (
      .clk (clk),
      .en  (ld[TRIG_ST+2*j +: 2]),
      .d_i (ch[j]),
      .lp  (lp[j]),
      .d_o (ch[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[OUT_S]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          rot_o_r[i][k] <= sat_rot(ch[NLINK].rot[i][k]);
        end
        pos_o_r[i] <= sat_pos(ch[NLINK].pos[i]);
      end
    end
  end

  assign in_ch.ready      = ld[0];
  assign out_ch.valid     = v_r[OUT_S];
  assign out_ch.rot_r0_c0 = rot_o_r[0][0];
  assign out_ch.rot_r0_c1 = rot_o_r[0][1];
  assign out_ch.rot_r0_c2 = rot_o_r[0][2];
  assign out_ch.rot_r1_c0 = rot_o_r[1][0];
  assign out_ch.rot_r1_c1 = rot_o_r[1][1];
  assign out_ch.rot_r1_c2 = rot_o_r[1][2];
  assign out_ch.rot_r2_c0 = rot_o_r[2][0];
  assign out_ch.rot_r2_c1 = rot_o_r[2][1];
  assign out_ch.rot_r2_c2 = rot_o_r[2][2];
  assign out_ch.pos_x     = pos_o_r[0];
  assign out_ch.pos_y     = pos_o_r[1];
  assign out_ch.pos_z     = pos_o_r[2];

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> ((&v_r) && !out_ch.ready))
    else $error("input blocked while the pipeline has an empty stage");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(v_r) <= $past($countones(v_r)) + 1) &&
    ($countones(v_r) + 1 >= $past($countones(v_r))))
    else $error("beat count in the pipeline changed by more than one");

  a_entry_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[0]) |-> $past(in_ch.valid && in_ch.ready))
    else $error("first stage filled without an accepted beat");

endmodule

@@ sv/afk_horner.sv @@
`timescale 1ns / 1ps
module afk_horner import afk_pkg::*; #(
  parameter int DIV = 72
) (
  input  logic       clk,
  input  logic [2:0] en,
  input  ufr_t       x2_i,
  input  ufr_t       t_i,
  output ufr_t       x2_o,
  output ufr_t       t_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
  localparam ufr_t        HALFD = ufr_t'(DIV / 2);
  localparam logic [33:0] DIVC  = 34'(DIV);

  ufr_t        m_r, x2a_r;
  ufr_t        u_r, q0_r, x2b_r;
  ufr_t        t_r, x2c_r;
  ufr_t        m_nxt, u_nxt, q0_nxt, t_nxt;
  logic [57:0] prod;
  logic [63:0] rprod;
  logic [33:0] rem;

  always_comb begin
    prod   = 58'(x2_i) * 58'(t_i);
    m_nxt  = ufr_t'((prod + (58'd1 << (FRAC - 1))) >> FRAC);
    u_nxt  = m_r + HALFD;
    rprod  = 64'(u_nxt) * 64'(RECIP);
    q0_nxt = ufr_t'(rprod[63:32]);
    rem    = 34'(u_r) - 34'(q0_r) * DIVC;
    t_nxt  = ONE_Q - (q0_r + ((rem >= DIVC) ? ufr_t'(1) : ufr_t'(0)));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r   <= m_nxt;
      x2a_r <= x2_i;
    end
    if (en[1]) begin
      u_r   <= u_nxt;
      q0_r  <= q0_nxt;
      x2b_r <= x2a_r;
    end
    if (en[2]) begin
      t_r   <= t_nxt;
      x2c_r <= x2b_r;
    end
  end

  assign x2_o = x2c_r;
  assign t_o  = t_r;

endmodule

@@ sv/afk_trig.sv @@
`timescale 1ns / 1ps
module afk_trig import afk_pkg::*; (
  input  logic               clk,
  input  logic [TRIG_ST-1:0] en,
  input  ang_t               ang,
  output cs_t                cs_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  trig_t      r_r    [14];
  logic [1:0] quad_r [17];
  ufr_t       x2_r;
  trig_t      s14_r, s15_r, s16_r;
  cs_t        cs_r;

  logic signed [35:0] r0, rr;
  logic [2:0]         npos, nneg;
  logic signed [3:0]  quad;
  ufr_t               x2_nxt;
  trig_t              s_nxt;
  cs_t                cs_nxt;

  ufr_t sx2 [5];
  ufr_t st  [5];
  ufr_t cx2 [6];
  ufr_t ct  [6];

  always_comb begin
    r0   = $signed({{4{ang[15]}}, ang, 16'b0});
    npos = 3'd0;
    nneg = 3'd0;
    for (int k = 0; k < 5; k++) begin
      if (r0 > QUARTER_PI_Q + 36'(k) * HALF_PI_Q) npos = npos + 3'd1;
      if (r0 < -(QUARTER_PI_Q + 36'(k) * HALF_PI_Q)) nneg = nneg + 3'd1;
    end
    quad   = $signed({1'b0, npos}) - $signed({1'b0, nneg});
    rr     = r0 - 36'(quad) * HALF_PI_Q;
    x2_nxt = ufr_t'(mulq(32'(r_r[0]), 32'(r_r[0])));
    s_nxt  = trig_t'(mulq(32'(r_r[13]), 32'($signed({1'b0, st[4]}))));
    unique case (quad_r[16])
      QUAD_0: begin
        cs_nxt.c = trig_t'({1'b0, ct[5]});
        cs_nxt.s = s16_r;
      end
      QUAD_1: begin
        cs_nxt.c = -s16_r;
        cs_nxt.s = trig_t'({1'b0, ct[5]});
      end
      QUAD_2: begin
        cs_nxt.c = -trig_t'({1'b0, ct[5]});
        cs_nxt.s = -s16_r;
      end
      QUAD_3: begin
        cs_nxt.c = s16_r;
        cs_nxt.s = -trig_t'({1'b0, ct[5]});
      end
      default: begin
        cs_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]    <= trig_t'(rr);
      quad_r[0] <= quad[1:0];
    end
    for (int k = 1; k < 14; k++) begin
      if (en[k]) r_r[k] <= r_r[k-1];
    end
    for (int k = 1; k < 17; k++) begin
      if (en[k]) quad_r[k] <= quad_r[k-1];
    end
    if (en[1]) x2_r <= x2_nxt;
    if (en[14]) s14_r <= s_nxt;
    if (en[15]) s15_r <= s14_r;
    if (en[16]) s16_r <= s15_r;
    if (en[17]) cs_r <= cs_nxt;
  end

  assign sx2[0] = x2_r;
  assign st[0]  = ONE_Q;
  assign cx2[0] = x2_r;
  assign ct[0]  = ONE_Q;

  for (genvar k = 0; k < 4; k++) begin : g_sin
    afk_horner #(.DIV(SIN_DIV[k])) u_step (
      .clk  (clk),
      .en   (en[2+3*k +: 3]),
      .x2_i (sx2[k]),
      .t_i  (st[k]),
      .x2_o (sx2[k+1]),
      .t_o  (st[k+1])
    );
  end

  for (genvar k = 0; k < 5; k++) begin : g_cos
    afk_horner #(.DIV(COS_DIV[k])) u_step (
      .clk  (clk),
      .en   (en[2+3*k +: 3]),
      .x2_i (cx2[k]),
      .t_i  (ct[k]),
      .x2_o (cx2[k+1]),
      .t_o  (ct[k+1])
    );
  end

  assign cs_o = cs_r;

endmodule

@@ sv/afk_link.sv @@
`timescale 1ns / 1ps
module afk_link import afk_pkg::*; #(
  parameter int J = 0
) (
  input  logic       clk,
  input  logic [1:0] en,
  input  chain_t     d_i,
  input  ofs_t [2:0] lp,
  output chain_t     d_o
);

  localparam int SA  = LINK_SA[J];
  localparam int CA  = LINK_CA[J];
  localparam int SGN = (CA != 0) ? 1 : SA;

  trig_t cv, sv;

  prd_t a_nxt [3], b_nxt [3], c_nxt [3], d_nxt [3];
  rot_t n2_nxt [3];
  prd_t pp_nxt [3][3];

  prd_t a_r [3], b_r [3], c_r [3], d_r [3];
  rot_t n2_r [3];
  prd_t pp_r [3][3];
  pos_t pos_r [3];
  cs_t  [NJ-1:0] cs_r;

  chain_t o_nxt, o_r;
  rot_t   ry;

  if (J < NJ) begin : g_joint
    assign cv = d_i.cs[J].c;
    assign sv = d_i.cs[J].s;
  end else begin : g_flange
    assign cv = CS_ID.c;
    assign sv = CS_ID.s;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ry        = (CA != 0) ? d_i.rot[i][1] : d_i.rot[i][2];
      a_nxt[i]  = mulq(d_i.rot[i][0], 32'(cv));
      b_nxt[i]  = mulq(ry, 32'(sv));
      c_nxt[i]  = mulq(d_i.rot[i][0], 32'(sv));
      d_nxt[i]  = mulq(ry, 32'(cv));
      n2_nxt[i] = ((SA > 0) ? -d_i.rot[i][1] : (SA < 0) ? d_i.rot[i][1] : rot_t'(0))
                + ((CA != 0) ? d_i.rot[i][2] : rot_t'(0));
      for (int k = 0; k < 3; k++) begin
        pp_nxt[i][k] = mulq(d_i.rot[i][k], 32'(lp[k]));
      end
    end
  end

  always_comb begin
    o_nxt.cs = cs_r;
    for (int i = 0; i < 3; i++) begin
      o_nxt.rot[i][0] = rot_t'(a_r[i]
                        + ((SGN > 0) ? b_r[i] : (SGN < 0) ? -b_r[i] : prd_t'(0)));
      o_nxt.rot[i][1] = rot_t'(-c_r[i]
                        + ((SGN > 0) ? d_r[i] : (SGN < 0) ? -d_r[i] : prd_t'(0)));
      o_nxt.rot[i][2] = n2_r[i];
      o_nxt.pos[i]    = pos_r[i] + 40'(pp_r[i][0]) + 40'(pp_r[i][1]) + 40'(pp_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
      d_r   <= d_nxt;
      n2_r  <= n2_nxt;
      pp_r  <= pp_nxt;
      for (int i = 0; i < 3; i++) pos_r[i] <= d_i.pos[i];
      cs_r  <= d_i.cs;
    end
    if (en[1]) o_r <= o_nxt;
  end

  assign d_o = o_r;

endmodule
